@@ design/rsd_pkg.sv @@
// ============================================================================
// rsd_pkg: shared constants and helpers for the string deframer
// Phase codes, result status codes, protocol characters and count widths.
// ============================================================================
package rsd_pkg;

  // Width of the internal length counters; reported counts saturate to 32 bits
  localparam int LENGTH_BITS = 32;
  localparam int REPORT_BITS = 32;

  // Protocol characters
  localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE   = 8'h39;  // '9'

  // Parser phases
  localparam logic [2:0] PH_HUNT       = 3'd0;
  localparam logic [2:0] PH_SIMPLE     = 3'd1;
  localparam logic [2:0] PH_BULK_FIRST = 3'd2;
  localparam logic [2:0] PH_BULK_HDR   = 3'd3;
  localparam logic [2:0] PH_BULK_BODY  = 3'd4;
  localparam logic [2:0] PH_WAIT_LF    = 3'd5;

  // End-of-string status codes
  localparam logic [1:0] ST_SIMPLE_OK = 2'd0;
  localparam logic [1:0] ST_BULK_OK   = 2'd1;
  localparam logic [1:0] ST_BULK_MISM = 2'd2;
  localparam logic [1:0] ST_NULL      = 2'd3;

  typedef logic [LENGTH_BITS-1:0] len_t;

  // Clamp an internal count to the 32-bit reported width
  function automatic logic [REPORT_BITS-1:0] sat_report(input len_t v);
    logic [LENGTH_BITS+REPORT_BITS-1:0] ext;
    ext = (LENGTH_BITS+REPORT_BITS)'(v);
    if (ext[LENGTH_BITS+REPORT_BITS-1:REPORT_BITS] != '0) begin
      return '1;
    end else begin
      return ext[REPORT_BITS-1:0];
    end
  endfunction

  // Saturating decimal accumulate: acc*10 + digit, clamped to all ones
  function automatic len_t dec_accum(input len_t acc, input logic [3:0] digit);
    logic [LENGTH_BITS+3:0] prod;
    prod = ((LENGTH_BITS+4)'(acc) << 3) + ((LENGTH_BITS+4)'(acc) << 1)
         + (LENGTH_BITS+4)'(digit);
    if (prod[LENGTH_BITS+3:LENGTH_BITS] != '0) begin
      return '1;
    end else begin
      return prod[LENGTH_BITS-1:0];
    end
  endfunction

endpackage

@@ design/resp_string_deframer.sv @@
// ============================================================================
// resp_string_deframer: simple and bulk string deframer
// Hunts for '+' or '$', passes body bytes and emits an end item with status,
// body length and declared length for each string.
// ============================================================================
// Results are registered: a result appears on out_* in the cycle after its byte is accepted.
// Throughput: one byte per cycle; parser state and result register update on
//   the same edge, so in_tready only drops while a held result is not taken.
// Reset (rst_n low, synchronous): parser hunts for a start marker, counters
//   cleared, output register empty.
module resp_string_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // buffer_end
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] out_byte, [39:8] body_length,
                                  // [71:40] declared_length
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // is_end
);

  // Parser state
  logic [2:0]         phase_r, phase_nxt;
  rsd_pkg::len_t      header_length_r, header_length_nxt;
  rsd_pkg::len_t      body_count_r, body_count_nxt;
  logic               digits_done_r, digits_done_nxt;
  logic               null_mark_r, null_mark_nxt;

  // Result register
  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic               out_end_r;
  logic [1:0]         out_status_r;
  logic [31:0]        out_blen_r;
  logic [31:0]        out_dlen_r;

  // Result of the current byte
  logic               res_valid;
  logic [7:0]         res_byte;
  logic               res_end;
  logic [1:0]         res_status;
  logic [31:0]        res_blen;
  logic [31:0]        res_dlen;

  logic               in_acc;
  logic               is_digit;
  rsd_pkg::len_t      body_inc;

  // Take a new request whenever the result slot is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign is_digit = (in_tdata >= rsd_pkg::CH_ZERO) && (in_tdata <= rsd_pkg::CH_NINE);
  assign body_inc = (body_count_r == '1) ? body_count_r : body_count_r + 1'b1;

  // Per-byte parse step
  always_comb begin
    phase_nxt         = phase_r;
    header_length_nxt = header_length_r;
    body_count_nxt    = body_count_r;
    digits_done_nxt   = digits_done_r;
    null_mark_nxt     = null_mark_r;
    res_valid         = 1'b0;
    res_byte          = 8'd0;
    res_end           = 1'b0;
    res_status        = rsd_pkg::ST_SIMPLE_OK;
    res_blen          = 32'd0;
    res_dlen          = 32'd0;

    case (phase_r)
      rsd_pkg::PH_HUNT: begin
        if (in_tdata == rsd_pkg::CH_PLUS) begin
          header_length_nxt = '0;
          body_count_nxt    = '0;
          digits_done_nxt   = 1'b0;
          null_mark_nxt     = 1'b0;
          phase_nxt         = rsd_pkg::PH_SIMPLE;
        end else if (in_tdata == rsd_pkg::CH_DOLLAR) begin
          header_length_nxt = '0;
          body_count_nxt    = '0;
          digits_done_nxt   = 1'b0;
          null_mark_nxt     = 1'b0;
          phase_nxt         = rsd_pkg::PH_BULK_FIRST;
        end
      end
      rsd_pkg::PH_SIMPLE: begin
        res_valid = 1'b1;
        if (in_tdata == rsd_pkg::CH_CR) begin
          res_end   = 1'b1;
          res_blen  = rsd_pkg::sat_report(body_count_r);
          phase_nxt = rsd_pkg::PH_WAIT_LF;
        end else begin
          res_byte       = in_tdata;
          body_count_nxt = body_inc;
        end
      end
      rsd_pkg::PH_BULK_FIRST, rsd_pkg::PH_BULK_HDR: begin
        if (in_tdata == rsd_pkg::CH_LF) begin
          if (null_mark_r) begin
            res_valid         = 1'b1;
            res_end           = 1'b1;
            res_status        = rsd_pkg::ST_NULL;
            phase_nxt         = rsd_pkg::PH_HUNT;
            header_length_nxt = '0;
            body_count_nxt    = '0;
            digits_done_nxt   = 1'b0;
            null_mark_nxt     = 1'b0;
          end else begin
            body_count_nxt = '0;
            phase_nxt      = rsd_pkg::PH_BULK_BODY;
          end
        end else if (phase_r == rsd_pkg::PH_BULK_FIRST && in_tdata == rsd_pkg::CH_MINUS) begin
          null_mark_nxt   = 1'b1;
          digits_done_nxt = 1'b1;
          phase_nxt       = rsd_pkg::PH_BULK_HDR;
        end else begin
          // digits accumulate until the first non-digit on the line
          if (!digits_done_r) begin
            if (is_digit) begin
              header_length_nxt = rsd_pkg::dec_accum(header_length_r, in_tdata[3:0]);
            end else begin
              digits_done_nxt = 1'b1;
            end
          end
          phase_nxt = rsd_pkg::PH_BULK_HDR;
        end
      end
      rsd_pkg::PH_BULK_BODY: begin
        res_valid = 1'b1;
        if (in_tdata == rsd_pkg::CH_CR) begin
          res_end    = 1'b1;
          res_status = (body_count_r == header_length_r) ? rsd_pkg::ST_BULK_OK
                                                         : rsd_pkg::ST_BULK_MISM;
          res_blen   = rsd_pkg::sat_report(body_count_r);
          res_dlen   = rsd_pkg::sat_report(header_length_r);
          phase_nxt  = rsd_pkg::PH_WAIT_LF;
        end else begin
          res_byte       = in_tdata;
          body_count_nxt = body_inc;
        end
      end
      rsd_pkg::PH_WAIT_LF: begin
        if (in_tdata == rsd_pkg::CH_LF) begin
          phase_nxt         = rsd_pkg::PH_HUNT;
          header_length_nxt = '0;
          body_count_nxt    = '0;
          digits_done_nxt   = 1'b0;
          null_mark_nxt     = 1'b0;
        end
      end
      default: begin
        phase_nxt         = rsd_pkg::PH_HUNT;
        header_length_nxt = '0;
        body_count_nxt    = '0;
        digits_done_nxt   = 1'b0;
        null_mark_nxt     = 1'b0;
      end
    endcase

    // buffer end drops any partial frame
    if (in_tlast) begin
      phase_nxt         = rsd_pkg::PH_HUNT;
      header_length_nxt = '0;
      body_count_nxt    = '0;
      digits_done_nxt   = 1'b0;
      null_mark_nxt     = 1'b0;
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= rsd_pkg::PH_HUNT;
      header_length_r <= '0;
      body_count_r    <= '0;
      digits_done_r   <= 1'b0;
      null_mark_r     <= 1'b0;
    end else if (in_acc) begin
      phase_r         <= phase_nxt;
      header_length_r <= header_length_nxt;
      body_count_r    <= body_count_nxt;
      digits_done_r   <= digits_done_nxt;
      null_mark_r     <= null_mark_nxt;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_acc && res_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_byte_r   <= res_byte;
      out_end_r    <= res_end;
      out_status_r <= res_status;
      out_blen_r   <= res_blen;
      out_dlen_r   <= res_dlen;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_dlen_r, out_blen_r, out_byte_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_end_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // a held result blocks new requests
  a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("request accepted while result held");

  // buffer end always leaves the parser hunting with counters cleared
  a_buffer_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (phase_r == rsd_pkg::PH_HUNT && body_count_r == '0
                              && header_length_r == '0))
    else $error("buffer end did not abandon frame");

  // hunting implies cleared frame counters
  a_hunt_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == rsd_pkg::PH_HUNT) |-> (body_count_r == '0 && header_length_r == '0
                                       && !null_mark_r))
    else $error("stale counters while hunting");

  // body byte items carry no status or lengths
  a_body_item_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tuser == rsd_pkg::ST_SIMPLE_OK
                                    && out_tdata[71:8] == '0))
    else $error("body item with nonzero status or length");

  // null end items report no lengths
  a_null_item_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast && out_tuser == rsd_pkg::ST_NULL) |-> (out_tdata == '0))
    else $error("null item with nonzero payload");

endmodule
